/* hdl/bfdh_pkg.sv */
`timescale 1ns / 1ps
// shared types and constants of the bloom filter double hash unit
package bfdh_pkg;

    // stream payload widths
    localparam int S_TDATA_W = 56;
    localparam int M_TDATA_W = 16;

    // configuration port
    localparam int CFG_AW = 1;
    localparam int CFG_DW = 13;

    // field widths
    localparam int MODE_W   = 3;
    localparam int HASH_W   = 32;
    localparam int INDEX_W  = 12;
    localparam int BYTE_W   = 8;
    localparam int SIZE_W   = 13;
    localparam int PCOUNT_W = 8;
    localparam int BITS_W   = SIZE_W + 3;

    // divider: 33-bit dividend so that 2^32 itself can be reduced
    localparam int DVD_W     = HASH_W + 1;
    localparam int DIV_STEPS = DVD_W;
    localparam int DIV_CNT_W = $clog2(DIV_STEPS + 1);

    // rotation of the probe step
    localparam int ROT_R = 17;

    // reset values of the registers
    localparam logic [SIZE_W-1:0]   FILTER_BYTES_RST = SIZE_W'(8);
    localparam logic [PCOUNT_W-1:0] PROBE_COUNT_RST  = PCOUNT_W'(6);

    // register indexes
    typedef enum logic [CFG_AW-1:0] {
        REG_FILTER_BYTES = 1'b0,
        REG_PROBE_COUNT  = 1'b1
    } reg_idx_t;

    // operation codes
    typedef enum logic [MODE_W-1:0] {
        MODE_CLEAR = 3'd0,
        MODE_ADD   = 3'd1,
        MODE_QUERY = 3'd2,
        MODE_WRITE = 3'd3,
        MODE_READ  = 3'd4
    } mode_t;

    // divider operand select
    typedef enum logic [1:0] {
        DIV_HASH  = 2'd0,
        DIV_DELTA = 2'd1,
        DIV_WRAP  = 2'd2
    } div_sel_t;

    // source of the read_value field
    typedef enum logic [1:0] {
        RD_ZERO = 2'd0,
        RD_MEM  = 2'd1,
        RD_PCNT = 2'd2
    } rd_src_t;

    // commands from controller to datapath
    typedef struct packed {
        logic     load;
        logic     clr_wr;
        logic     div_start;
        div_sel_t div_sel;
        logic     lat_h;
        logic     lat_d;
        logic     lat_w;
        logic     dmw;
        logic     probe_rd;
        logic     pos_adv;
        logic     add_wr;
        logic     byte_wr;
        logic     byte_rd;
        logic     out_load;
        logic     res_match;
        logic     res_status;
        rd_src_t  rd_src;
    } bfdh_cmd_t;

    // status from datapath to controller
    typedef struct packed {
        logic [MODE_W-1:0]   mode;
        logic                size_zero;
        logic                pc_over;
        logic                pc_zero;
        logic                idx_lt;
        logic                idx_eq;
        logic [PCOUNT_W-1:0] k_add;
        logic [PCOUNT_W-1:0] k_query;
        logic                div_busy;
        logic                bit_set;
        logic                clr_last;
        logic                out_free;
    } bfdh_sts_t;

endpackage

/* hdl/bfdh_mod_div.sv */
`timescale 1ns / 1ps
// restoring remainder unit, one dividend bit per cycle
module bfdh_mod_div (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          start,
    input  logic [bfdh_pkg::DVD_W-1:0]    dividend,
    input  logic [bfdh_pkg::BITS_W-1:0]   divisor,
    output logic                          busy,
    output logic [bfdh_pkg::BITS_W-1:0]   remainder
);
    import bfdh_pkg::*;

    logic [DIV_CNT_W-1:0] cnt_reg, cnt_next;
    logic [DVD_W-1:0]     dvd_reg, dvd_next;
    logic [BITS_W-1:0]    rem_reg, rem_next;
    logic [BITS_W:0]      trial;

    // one shift and conditional subtract per cycle
    always_comb begin
        trial    = {rem_reg, dvd_reg[DVD_W-1]};
        cnt_next = cnt_reg;
        dvd_next = dvd_reg;
        rem_next = rem_reg;
        if (start) begin
            cnt_next = DIV_CNT_W'(DIV_STEPS);
            dvd_next = dividend;
            rem_next = '0;
        end else if (busy) begin
            cnt_next = cnt_reg - 1'b1;
            dvd_next = {dvd_reg[DVD_W-2:0], 1'b0};
            if (trial >= {1'b0, divisor}) begin
                rem_next = BITS_W'(trial - {1'b0, divisor});
            end else begin
                rem_next = trial[BITS_W-1:0];
            end
        end
    end

    // step counter
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= '0;
        end else begin
            cnt_reg <= cnt_next;
        end
    end

    // operand registers
    always_ff @(posedge aclk) begin
        dvd_reg <= dvd_next;
        rem_reg <= rem_next;
    end

    assign busy      = (cnt_reg != '0);
    assign remainder = rem_reg;

endmodule

/* hdl/bfdh_datapath.sv */
`timescale 1ns / 1ps
// datapath: registers, filter store, probe position arithmetic and result register
module bfdh_datapath #(
    parameter int MAX_BYTES  = 4096,
    parameter int MAX_PROBES = 30
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  bfdh_pkg::bfdh_cmd_t             cmd,
    output bfdh_pkg::bfdh_sts_t             sts,
    input  logic [bfdh_pkg::S_TDATA_W-1:0]  s_tdata,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [bfdh_pkg::M_TDATA_W-1:0]  m_tdata,
    input  logic                            cfg_we,
    input  logic [bfdh_pkg::CFG_AW-1:0]     cfg_addr,
    input  logic [bfdh_pkg::CFG_DW-1:0]     cfg_wdata
);
    import bfdh_pkg::*;

    localparam int ADDR_W = $clog2(MAX_BYTES);

    // configuration registers
    logic [SIZE_W-1:0]   fbytes_reg;
    logic [PCOUNT_W-1:0] pcount_reg;

    // captured transaction
    logic [MODE_W-1:0]  mode_reg;
    logic [HASH_W-1:0]  hash_reg;
    logic [HASH_W-1:0]  delta_reg;
    logic [INDEX_W-1:0] idx_reg;
    logic [BYTE_W-1:0]  val_reg;
    logic               carry_reg;

    // probe position arithmetic
    logic [BITS_W-1:0] pos_reg;
    logic [BITS_W-1:0] dm_reg;
    logic [BITS_W-1:0] bmw_reg;
    logic [BITS_W-1:0] dmw_reg;

    // filter store
    logic [BYTE_W-1:0] mem [MAX_BYTES];
    logic [BYTE_W-1:0] mem_q_reg;
    logic [ADDR_W-1:0] clr_cnt_reg;

    // result register
    logic              out_valid_reg;
    logic              out_match_reg;
    logic [BYTE_W-1:0] out_rd_reg;
    logic              out_status_reg;

    logic [SIZE_W-1:0] size;
    logic [BITS_W-1:0] bits;
    logic [DVD_W-1:0]  div_dvd;
    logic              div_busy;
    logic [BITS_W-1:0] div_rem;
    logic [BITS_W:0]   dmw_sum;
    logic [BITS_W-1:0] step;
    logic [BITS_W:0]   pos_sum;
    logic [HASH_W:0]   hash_sum;
    logic [HASH_W-1:0] in_hash;
    logic [ADDR_W-1:0] pos_addr;
    logic [ADDR_W-1:0] idx_addr;
    logic              mem_we;
    logic [ADDR_W-1:0] mem_wa;
    logic [BYTE_W-1:0] mem_wd;
    logic              mem_re;
    logic [ADDR_W-1:0] mem_ra;
    logic [BYTE_W-1:0] rd_value;

    // size in use and bit count
    always_comb begin
        if (32'(fbytes_reg) > 32'(MAX_BYTES)) begin
            size = SIZE_W'(MAX_BYTES);
        end else begin
            size = fbytes_reg;
        end
        bits = {size, 3'b000};
    end

    // configuration writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fbytes_reg <= FILTER_BYTES_RST;
            pcount_reg <= PROBE_COUNT_RST;
        end else if (cfg_we) begin
            unique case (cfg_addr)
                REG_FILTER_BYTES: fbytes_reg <= cfg_wdata[SIZE_W-1:0];
                REG_PROBE_COUNT:  pcount_reg <= cfg_wdata[PCOUNT_W-1:0];
                default: ;
            endcase
        end
    end

    // capture of the input transaction
    assign in_hash = s_tdata[MODE_W +: HASH_W];

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            mode_reg  <= s_tdata[0 +: MODE_W];
            idx_reg   <= s_tdata[MODE_W + HASH_W +: INDEX_W];
            val_reg   <= s_tdata[MODE_W + HASH_W + INDEX_W +: BYTE_W];
            delta_reg <= (in_hash >> ROT_R) | (in_hash << (HASH_W - ROT_R));
        end
    end

    // running hash and its carry out of 32 bits
    assign hash_sum = {1'b0, hash_reg} + {1'b0, delta_reg};

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            hash_reg  <= in_hash;
            carry_reg <= 1'b0;
        end else if (cmd.probe_rd) begin
            hash_reg  <= hash_sum[HASH_W-1:0];
            carry_reg <= hash_sum[HASH_W];
        end
    end

    // remainder unit operand
    always_comb begin
        unique case (cmd.div_sel)
            DIV_HASH:  div_dvd = {1'b0, hash_reg};
            DIV_DELTA: div_dvd = {1'b0, delta_reg};
            DIV_WRAP:  div_dvd = {1'b1, {HASH_W{1'b0}}};
            default:   div_dvd = '0;
        endcase
    end

    bfdh_mod_div u_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .start     (cmd.div_start),
        .dividend  (div_dvd),
        .divisor   (bits),
        .busy      (div_busy),
        .remainder (div_rem)
    );

    // step residues: plain step, and step folded with the 2^32 wrap
    assign dmw_sum = {1'b0, dm_reg} + {1'b0, bmw_reg};
    assign step    = carry_reg ? dmw_reg : dm_reg;
    assign pos_sum = {1'b0, pos_reg} + {1'b0, step};

    always_ff @(posedge aclk) begin
        if (cmd.lat_h) begin
            pos_reg <= div_rem;
        end else if (cmd.pos_adv) begin
            if (pos_sum >= {1'b0, bits}) begin
                pos_reg <= BITS_W'(pos_sum - {1'b0, bits});
            end else begin
                pos_reg <= pos_sum[BITS_W-1:0];
            end
        end
        if (cmd.lat_d) begin
            dm_reg <= div_rem;
        end
        if (cmd.lat_w) begin
            bmw_reg <= bits - div_rem;
        end
        if (cmd.dmw) begin
            if (dmw_sum >= {1'b0, bits}) begin
                dmw_reg <= BITS_W'(dmw_sum - {1'b0, bits});
            end else begin
                dmw_reg <= dmw_sum[BITS_W-1:0];
            end
        end
    end

    // clearing sweep address
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clr_cnt_reg <= '0;
        end else if (cmd.load) begin
            clr_cnt_reg <= '0;
        end else if (cmd.clr_wr) begin
            clr_cnt_reg <= clr_cnt_reg + 1'b1;
        end
    end

    // store port selection
    assign pos_addr = ADDR_W'(pos_reg[BITS_W-1:3]);
    assign idx_addr = ADDR_W'(idx_reg);

    always_comb begin
        mem_we = cmd.clr_wr || cmd.add_wr || cmd.byte_wr;
        mem_wa = idx_addr;
        mem_wd = val_reg;
        priority if (cmd.clr_wr) begin
            mem_wa = clr_cnt_reg;
            mem_wd = '0;
        end else if (cmd.add_wr) begin
            mem_wa = pos_addr;
            mem_wd = mem_q_reg | (BYTE_W'(1) << pos_reg[2:0]);
        end else begin
            mem_wa = idx_addr;
            mem_wd = val_reg;
        end
        mem_re = cmd.probe_rd || cmd.byte_rd;
        mem_ra = cmd.probe_rd ? pos_addr : idx_addr;
    end

    // filter store, one write and one registered read
    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[mem_wa] <= mem_wd;
        end
        if (mem_re) begin
            mem_q_reg <= mem[mem_ra];
        end
    end

    // result register
    always_comb begin
        unique case (cmd.rd_src)
            RD_MEM:  rd_value = mem_q_reg;
            RD_PCNT: rd_value = pcount_reg;
            default: rd_value = '0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (cmd.out_load) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.out_load) begin
            out_match_reg  <= cmd.res_match;
            out_rd_reg     <= rd_value;
            out_status_reg <= cmd.res_status;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(M_TDATA_W - BYTE_W - 2){1'b0}}, out_status_reg, out_rd_reg,
                       out_match_reg};

    // status towards the controller
    always_comb begin
        sts.mode      = mode_reg;
        sts.size_zero = (size == '0);
        sts.pc_over   = (32'(pcount_reg) > 32'(MAX_PROBES));
        sts.pc_zero   = (pcount_reg == '0);
        sts.idx_lt    = ({1'b0, idx_reg} < size);
        sts.idx_eq    = ({1'b0, idx_reg} == size);
        if (pcount_reg == '0) begin
            sts.k_add = PCOUNT_W'(1);
        end else if (32'(pcount_reg) > 32'(MAX_PROBES)) begin
            sts.k_add = PCOUNT_W'(MAX_PROBES);
        end else begin
            sts.k_add = pcount_reg;
        end
        sts.k_query  = pcount_reg;
        sts.div_busy = div_busy;
        sts.bit_set  = mem_q_reg[pos_reg[2:0]];
        sts.clr_last = (clr_cnt_reg == ADDR_W'(MAX_BYTES - 1));
        sts.out_free = !out_valid_reg || m_tready;
    end

    // a new result never overwrites one that has not been taken
    assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.out_load |-> (!out_valid_reg || m_tready))
        else $error("result register overwritten");

    // probe position stays inside the filter
    assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.probe_rd |-> (pos_reg < bits))
        else $error("probe position beyond filter size");

endmodule

/* hdl/bfdh_ctrl.sv */
`timescale 1ns / 1ps
// controller: sequences clearing, remainder runs, probes and result hand-off
module bfdh_ctrl #(
    parameter int MAX_PROBES = 30
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    output bfdh_pkg::bfdh_cmd_t  cmd,
    input  bfdh_pkg::bfdh_sts_t  sts
);
    import bfdh_pkg::*;

    localparam int K_W = $clog2(MAX_PROBES + 1);

    typedef enum logic [9:0] {
        ST_IDLE   = 10'b00_0000_0001,
        ST_DECODE = 10'b00_0000_0010,
        ST_CLEAR  = 10'b00_0000_0100,
        ST_DIVH   = 10'b00_0000_1000,
        ST_DIVD   = 10'b00_0001_0000,
        ST_DIVW   = 10'b00_0010_0000,
        ST_DMW    = 10'b00_0100_0000,
        ST_PRD    = 10'b00_1000_0000,
        ST_PCHK   = 10'b01_0000_0000,
        ST_DONE   = 10'b10_0000_0000
    } state_t;

    state_t         state_reg, state_next;
    logic           init_reg, init_next;
    logic [K_W-1:0] probes_reg, probes_next;
    logic           match_reg, match_next;
    logic           status_reg, status_next;
    rd_src_t        rd_src_reg, rd_src_next;

    // next state and commands
    always_comb begin
        state_next  = state_reg;
        init_next   = init_reg;
        probes_next = probes_reg;
        match_next  = match_reg;
        status_next = status_reg;
        rd_src_next = rd_src_reg;
        cmd         = '0;
        cmd.div_sel = DIV_HASH;
        cmd.rd_src  = rd_src_reg;
        cmd.res_match  = match_reg;
        cmd.res_status = status_reg;
        s_tready    = 1'b0;

        unique case (state_reg)
            ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    cmd.load    = 1'b1;
                    match_next  = 1'b0;
                    status_next = 1'b0;
                    rd_src_next = RD_ZERO;
                    state_next  = ST_DECODE;
                end
            end
            ST_DECODE: begin
                state_next = ST_DONE;
                unique case (sts.mode)
                    MODE_CLEAR: begin
                        state_next = ST_CLEAR;
                    end
                    MODE_ADD: begin
                        if (sts.size_zero) begin
                            status_next = 1'b1;
                        end else begin
                            cmd.div_start = 1'b1;
                            probes_next   = K_W'(sts.k_add);
                            state_next    = ST_DIVH;
                        end
                    end
                    MODE_QUERY: begin
                        priority if (sts.size_zero) begin
                            match_next = 1'b0;
                        end else if (sts.pc_over || sts.pc_zero) begin
                            match_next = 1'b1;
                        end else begin
                            match_next    = 1'b1;
                            cmd.div_start = 1'b1;
                            probes_next   = K_W'(sts.k_query);
                            state_next    = ST_DIVH;
                        end
                    end
                    MODE_WRITE: begin
                        if (sts.idx_lt) begin
                            cmd.byte_wr = 1'b1;
                        end else begin
                            status_next = 1'b1;
                        end
                    end
                    MODE_READ: begin
                        priority if (sts.idx_lt) begin
                            cmd.byte_rd = 1'b1;
                            rd_src_next = RD_MEM;
                        end else if (sts.idx_eq) begin
                            rd_src_next = RD_PCNT;
                        end else begin
                            status_next = 1'b1;
                        end
                    end
                    default: begin
                        status_next = 1'b1;
                    end
                endcase
            end
            ST_CLEAR: begin
                cmd.clr_wr = 1'b1;
                if (sts.clr_last) begin
                    init_next  = 1'b0;
                    state_next = init_reg ? ST_IDLE : ST_DONE;
                end
            end
            ST_DIVH: begin
                if (!sts.div_busy) begin
                    cmd.lat_h     = 1'b1;
                    cmd.div_start = 1'b1;
                    cmd.div_sel   = DIV_DELTA;
                    state_next    = ST_DIVD;
                end
            end
            ST_DIVD: begin
                cmd.div_sel = DIV_DELTA;
                if (!sts.div_busy) begin
                    cmd.lat_d     = 1'b1;
                    cmd.div_start = 1'b1;
                    cmd.div_sel   = DIV_WRAP;
                    state_next    = ST_DIVW;
                end
            end
            ST_DIVW: begin
                cmd.div_sel = DIV_WRAP;
                if (!sts.div_busy) begin
                    cmd.lat_w  = 1'b1;
                    state_next = ST_DMW;
                end
            end
            ST_DMW: begin
                cmd.dmw    = 1'b1;
                state_next = ST_PRD;
            end
            ST_PRD: begin
                cmd.probe_rd = 1'b1;
                state_next   = ST_PCHK;
            end
            ST_PCHK: begin
                cmd.pos_adv = 1'b1;
                probes_next = probes_reg - 1'b1;
                priority if (sts.mode == MODE_QUERY && !sts.bit_set) begin
                    match_next = 1'b0;
                    state_next = ST_DONE;
                end else if (probes_reg == K_W'(1)) begin
                    cmd.add_wr = (sts.mode == MODE_ADD);
                    state_next = ST_DONE;
                end else begin
                    cmd.add_wr = (sts.mode == MODE_ADD);
                    state_next = ST_PRD;
                end
            end
            ST_DONE: begin
                if (sts.out_free) begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // control registers, reset starts the clearing sweep
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= ST_CLEAR;
            init_reg   <= 1'b1;
            probes_reg <= '0;
        end else begin
            state_reg  <= state_next;
            init_reg   <= init_next;
            probes_reg <= probes_next;
        end
    end

    // result fields held until hand-off
    always_ff @(posedge aclk) begin
        match_reg  <= match_next;
        status_reg <= status_next;
        rd_src_reg <= rd_src_next;
    end

    // the remainder unit is only started when free
    assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.div_start |-> !sts.div_busy)
        else $error("remainder unit restarted while busy");

    // every probe check has a probe left to do
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_PCHK) |-> (probes_reg != '0))
        else $error("probe check with no probe left");

endmodule

/* hdl/bloom_filter_double_hash_unit.sv */
`timescale 1ns / 1ps
// top level of the bloom filter double hash unit
//
//  channel   direction  handshake            payload
//  s_        in         s_tvalid / s_tready  mode, key_hash, byte_index, byte_value
//  m_        out        m_tvalid / m_tready  is_match, read_value, status
//  cfg_      in         cfg_we               filter_bytes (0), probe_count (1)
//
//  byte write and read, and unknown modes: accept, decode, then result hand-off.
//  add and query: up to k probes; three 33-step remainder runs
//  (hash, step, 2^32 modulo the bit count) on one shared unit come first, then
//  each probe passes a read and a check state on the single store port.
//  clear: all MAX_BYTES bytes swept, one byte written per cycle.
//  after reset all MAX_BYTES bytes of the store are swept to zero with s_tready low.
//  one transaction at a time; the next is taken while a result waits in m_tdata.
module bloom_filter_double_hash_unit #(
    parameter int MAX_BYTES  = 4096,
    parameter int MAX_PROBES = 30
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // mode[2:0], key_hash[34:3], byte_index[46:35], byte_value[54:47], zero[55]
    input  logic [bfdh_pkg::S_TDATA_W-1:0]  s_tdata,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // is_match[0], read_value[8:1], status[9], zero[15:10]
    output logic [bfdh_pkg::M_TDATA_W-1:0]  m_tdata,
    input  logic                            cfg_we,
    input  logic [bfdh_pkg::CFG_AW-1:0]     cfg_addr,
    input  logic [bfdh_pkg::CFG_DW-1:0]     cfg_wdata
);
    import bfdh_pkg::*;

    bfdh_cmd_t cmd;
    bfdh_sts_t sts;

    // sequencer
    bfdh_ctrl #(
        .MAX_PROBES (MAX_PROBES)
    ) u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .cmd      (cmd),
        .sts      (sts)
    );

    // store and arithmetic
    bfdh_datapath #(
        .MAX_BYTES  (MAX_BYTES),
        .MAX_PROBES (MAX_PROBES)
    ) u_datapath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd       (cmd),
        .sts       (sts),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata)
    );

endmodule

/* sim/testbench.sv */
`timescale 1ns / 1ps
// self-checking testbench of the bloom filter double hash unit
module testbench;
    import bfdh_pkg::*;

    localparam int MAX_BYTES   = 4096;
    localparam int MAX_PROBES  = 30;
    localparam int NUM_PHASES  = 11;
    localparam int PHASE_ITEMS = 48;
    localparam int HOLD_PHASE  = 3;
    localparam int HOLD_CYCLES = 400;
    localparam int POOL_DEPTH  = 32;

    // one input transaction, fields as carried on s_tdata
    typedef struct packed {
        logic [MODE_W-1:0]  mode;
        logic [HASH_W-1:0]  key_hash;
        logic [INDEX_W-1:0] byte_index;
        logic [BYTE_W-1:0]  byte_value;
    } request_t;

    // one result transaction, fields as carried on m_tdata
    typedef struct packed {
        logic              is_match;
        logic [BYTE_W-1:0] read_value;
        logic              status;
    } reply_t;

    // shadow filter, expected replies and failure count
    class filter_tracker;
        logic [BYTE_W-1:0]   shadow_bytes [MAX_BYTES];
        logic [SIZE_W-1:0]   filter_bytes;
        logic [PCOUNT_W-1:0] probe_count;
        reply_t              pending_replies [$];
        int                  failures;

        function new();
            foreach (shadow_bytes[j]) shadow_bytes[j] = '0;
            filter_bytes = FILTER_BYTES_RST;
            probe_count  = PROBE_COUNT_RST;
            failures     = 0;
        endfunction

        function void set_register(reg_idx_t idx, logic [CFG_DW-1:0] value);
            if (idx == REG_FILTER_BYTES) filter_bytes = value[SIZE_W-1:0];
            else probe_count = value[PCOUNT_W-1:0];
        endfunction

        // sizes above the store capacity fold to the capacity
        function int unsigned size_in_use();
            return (filter_bytes > MAX_BYTES) ? MAX_BYTES : filter_bytes;
        endfunction

        function reply_t compute_reply(request_t req);
            reply_t            rep;
            int unsigned       size, nbits, k, pos;
            logic [HASH_W-1:0] h, delta;
            rep   = '0;
            size  = size_in_use();
            nbits = size * 8;
            h     = req.key_hash;
            delta = {h[ROT_R-1:0], h[HASH_W-1:ROT_R]};
            case (req.mode)
                MODE_CLEAR: begin
                    foreach (shadow_bytes[j]) shadow_bytes[j] = '0;
                end
                MODE_ADD: begin
                    if (size == 0) begin
                        rep.status = 1'b1;
                    end else begin
                        // probe count clamped to 1..MAX_PROBES
                        k = probe_count;
                        if (k < 1) k = 1;
                        if (k > MAX_PROBES) k = MAX_PROBES;
                        for (int i = 0; i < k; i++) begin
                            pos = h % nbits;
                            shadow_bytes[pos >> 3][pos % 8] = 1'b1;
                            h = h + delta;
                        end
                    end
                end
                MODE_QUERY: begin
                    if (size != 0) begin
                        // oversized count matches with no probing
                        rep.is_match = 1'b1;
                        if (probe_count <= MAX_PROBES) begin
                            for (int i = 0; i < probe_count; i++) begin
                                pos = h % nbits;
                                if (!shadow_bytes[pos >> 3][pos % 8]) begin
                                    rep.is_match = 1'b0;
                                    break;
                                end
                                h = h + delta;
                            end
                        end
                    end
                end
                MODE_WRITE: begin
                    if (req.byte_index < size) shadow_bytes[req.byte_index] = req.byte_value;
                    else rep.status = 1'b1;
                end
                MODE_READ: begin
                    // one past the last byte gives the probe count
                    if (req.byte_index < size) rep.read_value = shadow_bytes[req.byte_index];
                    else if (req.byte_index == size) rep.read_value = probe_count;
                    else rep.status = 1'b1;
                end
                default: begin
                    rep.status = 1'b1;
                end
            endcase
            return rep;
        endfunction

        function void take_request(request_t req);
            pending_replies.push_back(compute_reply(req));
        endfunction

        function void note_failure(string text);
            failures++;
            if (failures <= 10) $display("%0t: %s", $time, text);
        endfunction

        function void check_response(logic [M_TDATA_W-1:0] word);
            reply_t got, want;
            got.is_match   = word[0];
            got.read_value = word[8:1];
            got.status     = word[9];
            if (pending_replies.size() == 0) begin
                note_failure($sformatf("unexpected result: match %0b value 0x%02h status %0b",
                                       got.is_match, got.read_value, got.status));
                return;
            end
            want = pending_replies.pop_front();
            if (got.is_match !== want.is_match || got.read_value !== want.read_value ||
                got.status !== want.status) begin
                note_failure($sformatf({"result mismatch: expected match %0b value 0x%02h ",
                                        "status %0b, got match %0b value 0x%02h status %0b"},
                                       want.is_match, want.read_value, want.status,
                                       got.is_match, got.read_value, got.status));
            end
        endfunction
    endclass

    logic                 aclk;
    logic                 aresetn;
    logic                 s_tvalid;
    logic                 s_tready;
    // mode[2:0], key_hash[34:3], byte_index[46:35], byte_value[54:47], zero[55]
    logic [S_TDATA_W-1:0] s_tdata;
    logic                 m_tvalid;
    logic                 m_tready;
    // is_match[0], read_value[8:1], status[9], zero[15:10]
    logic [M_TDATA_W-1:0] m_tdata;
    logic                 cfg_we;
    logic [CFG_AW-1:0]    cfg_addr;
    logic [CFG_DW-1:0]    cfg_wdata;

    filter_tracker     tracker;
    int unsigned       idle_pct;
    logic              hold_req;
    logic [HASH_W-1:0] added_hashes [$];

    // register settings per phase, extremes included
    int unsigned phase_bytes  [NUM_PHASES] = '{0, 16, 64, 4096, 8191, 100, 1, 512, 4095, 8, 2048};
    int unsigned phase_probes [NUM_PHASES] = '{6, 0, 1, 30, 31, 255, 3, 30, 8, 20, 4};

    bloom_filter_double_hash_unit #(
        .MAX_BYTES  (MAX_BYTES),
        .MAX_PROBES (MAX_PROBES)
    ) uut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata)
    );

    function automatic request_t request_of(logic [MODE_W-1:0] mode, logic [HASH_W-1:0] hash,
                                            int unsigned idx, logic [BYTE_W-1:0] value);
        request_t req;
        req.mode       = mode;
        req.key_hash   = hash;
        req.byte_index = INDEX_W'(idx);
        req.byte_value = value;
        return req;
    endfunction

    // byte address: mostly in range, sometimes at or just past the size or anywhere in the store
    function automatic int unsigned pick_index(int unsigned size);
        int unsigned roll;
        roll = $urandom_range(0, 9);
        if (roll == 0 && size < MAX_BYTES) return size;
        if (roll == 1 && size + 1 < MAX_BYTES) return size + 1;
        if (roll <= 2 || size == 0) return $urandom_range(0, MAX_BYTES - 1);
        return $urandom_range(0, size - 1);
    endfunction

    // adds followed by queries of the same keys, mixed with byte traffic and noise
    function automatic request_t make_request();
        int unsigned       roll, size;
        logic [HASH_W-1:0] hash;
        logic [BYTE_W-1:0] value;
        roll  = $urandom_range(0, 99);
        size  = tracker.size_in_use();
        hash  = $urandom();
        value = BYTE_W'($urandom());
        if (roll < 2) begin
            added_hashes.delete();
            return request_of(MODE_CLEAR, hash, pick_index(size), value);
        end
        if (roll < 30) begin
            added_hashes.push_back(hash);
            if (added_hashes.size() > POOL_DEPTH) void'(added_hashes.pop_front());
            return request_of(MODE_ADD, hash, pick_index(size), value);
        end
        if (roll < 45 && added_hashes.size() != 0)
            return request_of(MODE_QUERY, added_hashes[$urandom_range(0, added_hashes.size() - 1)],
                              pick_index(size), value);
        if (roll < 60) return request_of(MODE_QUERY, hash, pick_index(size), value);
        if (roll < 72) return request_of(MODE_WRITE, hash, pick_index(size), value);
        if (roll < 92) return request_of(MODE_READ, hash, pick_index(size), value);
        return request_of(MODE_W'(MODE_READ + $urandom_range(1, 3)), hash, pick_index(size), value);
    endfunction

    // offer one transaction, with an optional gap before it
    task automatic offer_request(request_t req);
        if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
            s_tvalid = 1'b0;
            repeat ($urandom_range(1, 6)) @(negedge aclk);
        end
        s_tvalid = 1'b1;
        s_tdata  = {1'b0, req.byte_value, req.byte_index, req.key_hash, req.mode};
        do @(posedge aclk); while (!s_tready);
        tracker.take_request(req);
        @(negedge aclk);
    endtask

    task automatic program_register(reg_idx_t idx, int unsigned value);
        cfg_we    = 1'b1;
        cfg_addr  = idx;
        cfg_wdata = CFG_DW'(value);
        tracker.set_register(idx, CFG_DW'(value));
        @(negedge aclk);
        cfg_we = 1'b0;
    endtask

    task automatic wait_for_drain();
        s_tvalid = 1'b0;
        while (tracker.pending_replies.size() != 0) @(negedge aclk);
        repeat (8) @(negedge aclk);
    endtask

    // clock
    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // result side ready, with random stalls and one long hold-off
    initial begin
        int unsigned stall_left, hold_left;
        m_tready   = 1'b0;
        stall_left = 0;
        hold_left  = 0;
        forever begin
            @(negedge aclk);
            if (hold_req) begin
                hold_left = HOLD_CYCLES;
                hold_req  = 1'b0;
            end
            if (hold_left != 0) begin
                m_tready = 1'b0;
                hold_left--;
            end else if (stall_left != 0) begin
                m_tready = 1'b0;
                stall_left--;
            end else if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
                m_tready   = 1'b0;
                stall_left = $urandom_range(0, 5);
            end else begin
                m_tready = 1'b1;
            end
        end
    end

    // result monitor
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) tracker.check_response(m_tdata);
    end

    // stimulus
    initial begin
        tracker   = new();
        aresetn   = 1'b0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        cfg_we    = 1'b0;
        cfg_addr  = '0;
        cfg_wdata = '0;
        idle_pct  = 20;
        hold_req  = 1'b0;
        repeat (11) @(negedge aclk);
        aresetn = 1'b1;

        // store sweep after reset
        while (!s_tready) @(negedge aclk);

        // directed part on the reset settings: eight bytes, six probes
        offer_request(request_of(MODE_READ, 32'h0, 0, 8'h00));
        offer_request(request_of(MODE_READ, 32'h0, 8, 8'h00));
        offer_request(request_of(MODE_READ, 32'h0, 9, 8'h00));
        offer_request(request_of(MODE_READ, 32'h0, MAX_BYTES - 1, 8'h00));
        offer_request(request_of(MODE_WRITE, 32'h0, 0, 8'hFF));
        offer_request(request_of(MODE_WRITE, 32'h0, 7, 8'h80));
        offer_request(request_of(MODE_WRITE, 32'h0, 8, 8'h55));
        offer_request(request_of(MODE_WRITE, 32'h0, MAX_BYTES - 1, 8'hAA));
        offer_request(request_of(MODE_READ, 32'h0, 0, 8'h00));
        offer_request(request_of(MODE_READ, 32'h0, 7, 8'h00));
        offer_request(request_of(MODE_CLEAR, 32'h0, 0, 8'h00));
        offer_request(request_of(MODE_READ, 32'h0, 0, 8'h00));
        offer_request(request_of(MODE_ADD, 32'h0000_0000, 0, 8'h00));
        offer_request(request_of(MODE_ADD, 32'hFFFF_FFFF, 0, 8'h00));
        offer_request(request_of(MODE_ADD, 32'h1234_5678, 0, 8'h00));
        offer_request(request_of(MODE_QUERY, 32'h0000_0000, 0, 8'h00));
        offer_request(request_of(MODE_QUERY, 32'hFFFF_FFFF, 0, 8'h00));
        offer_request(request_of(MODE_QUERY, 32'h1234_5678, 0, 8'h00));
        offer_request(request_of(MODE_QUERY, 32'h9E37_79B9, 0, 8'h00));
        // unused mode codes
        for (int m = 1; m <= 3; m++)
            offer_request(request_of(MODE_W'(MODE_READ + m), 32'h0, 0, 8'h00));

        // random phases, registers changed only once the unit is idle
        for (int p = 0; p < NUM_PHASES; p++) begin
            wait_for_drain();
            program_register(REG_FILTER_BYTES, phase_bytes[p]);
            program_register(REG_PROBE_COUNT, phase_probes[p]);
            if (p == NUM_PHASES - 1) idle_pct = 0;
            else if (p % 3 == 0) idle_pct = 25;
            else if (p % 3 == 1) idle_pct = 10;
            else idle_pct = 0;
            if (p == HOLD_PHASE) hold_req = 1'b1;
            repeat (PHASE_ITEMS) offer_request(make_request());
        end

        wait_for_drain();
        repeat (200) @(posedge aclk);
        if (tracker.failures == 0 && tracker.pending_replies.size() == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

    // run limit
    initial begin
        #100_000_000;
        $display("TB_ERROR");
        $finish;
    end

endmodule

/* filelist.f */
hdl/bfdh_pkg.sv
hdl/bfdh_mod_div.sv
hdl/bfdh_datapath.sv
hdl/bfdh_ctrl.sv
hdl/bloom_filter_double_hash_unit.sv
sim/testbench.sv
